### design/vog_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voxel occupancy grid.
package vog_pkg;

  localparam int POS_W   = 24;   // signed Q15.8 coordinate
  localparam int CELLS_W = 7;
  localparam int INV_W   = 24;   // unsigned Q8.16
  localparam int DIFF_W  = POS_W + 1;
  localparam int PROD_W  = DIFF_W + INV_W;
  localparam int FRAC_W  = 24;   // fraction bits of the product
  localparam int Q_W     = PROD_W - FRAC_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 24;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  typedef logic [CFG_AW-1:0] cfg_idx_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t CFG_CELLS_X  = 3'd3;
  localparam cfg_idx_t CFG_CELLS_Y  = 3'd4;
  localparam cfg_idx_t CFG_CELLS_Z  = 3'd5;
  localparam cfg_idx_t CFG_INV_RES  = 3'd6;

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } point_t;

  typedef struct packed {
    logic occupied;
    logic out_of_bounds;
  } result_t;

  // Control that travels with a computed cell address.
  typedef struct packed {
    logic valid;
    logic opcode;
    logic inb;
  } lookup_ctl_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } grid_state_t;

endpackage

### design/vog_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for points and query results.
interface vog_point_if;
  import vog_pkg::*;
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vog_result_if;
  import vog_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/vog_index.sv
`timescale 1ns / 1ps
// Two-stage cell index unit: offset, scale, round and bounds check per axis.
module vog_index #(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int MAX_CELLS_Z = 64,
  localparam int ROWS  = MAX_CELLS_X * MAX_CELLS_Y,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int ZW    = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  load,
  input  vog_pkg::point_t                       point,
  input  logic signed [vog_pkg::POS_W-1:0]      origin_x,
  input  logic signed [vog_pkg::POS_W-1:0]      origin_y,
  input  logic signed [vog_pkg::POS_W-1:0]      origin_z,
  input  logic        [vog_pkg::CELLS_W-1:0]    cells_x,
  input  logic        [vog_pkg::CELLS_W-1:0]    cells_y,
  input  logic        [vog_pkg::CELLS_W-1:0]    cells_z,
  input  logic        [vog_pkg::INV_W-1:0]      inv_resolution,
  output vog_pkg::lookup_ctl_t                  ctl,
  output logic        [ROW_W-1:0]               row,
  output logic        [ZW-1:0]                  zbit
);
  import vog_pkg::*;

  localparam int XW = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int YW = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int MAXC [3] = '{MAX_CELLS_X, MAX_CELLS_Y, MAX_CELLS_Z};

  logic signed [POS_W-1:0]  pos_a  [3];
  logic signed [POS_W-1:0]  org_a  [3];
  logic        [CELLS_W-1:0] cells_a [3];

  logic                     v1, v2;
  logic                     op1, op2;
  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [PROD_W-1:0] p2 [3];

  logic [PROD_W-1:0] mag  [3];
  logic [PROD_W-1:0] rsum [3];
  logic [Q_W-1:0]    q    [3];
  logic              ok   [3];

  logic [XW-1:0] ix;
  logic [YW-1:0] iy;

  assign pos_a   = '{point.pos_x, point.pos_y, point.pos_z};
  assign org_a   = '{origin_x, origin_y, origin_z};
  assign cells_a = '{cells_x, cells_y, cells_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= load;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= point.opcode;
      op2 <= op1;
      for (int a = 0; a < 3; a++) begin
        d1[a] <= DIFF_W'(pos_a[a]) - DIFF_W'(org_a[a]);
        p2[a] <= PROD_W'(d1[a]) * PROD_W'($signed({1'b0, inv_resolution}));
      end
    end
  end

  // Round half away from zero on the magnitude; a negative product is in
  // bounds only when it rounds to zero.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a]  = p2[a][PROD_W-1] ? PROD_W'(-p2[a]) : PROD_W'(p2[a]);
      rsum[a] = mag[a] + ROUND_HALF;
      q[a]    = rsum[a][PROD_W-1:FRAC_W];
      ok[a]   = (!p2[a][PROD_W-1] || (q[a] == '0)) &&
                (q[a] < Q_W'(cells_a[a])) && (q[a] < Q_W'(MAXC[a]));
    end
  end

  assign ix   = q[0][XW-1:0];
  assign iy   = q[1][YW-1:0];
  assign zbit = q[2][ZW-1:0];
  assign row  = ROW_W'(ix) * ROW_W'(MAX_CELLS_Y) + ROW_W'(iy);

  assign ctl.valid  = v2;
  assign ctl.opcode = op2;
  assign ctl.inb    = ok[0] && ok[1] && ok[2];

endmodule

### design/voxel_occupancy_grid.sv
`timescale 1ns / 1ps
// Voxel occupancy grid top level: config registers, grid memory, result stage.
//
// Points enter on pts (opcode, pos_x/y/z, signed Q15.8). A mark sets the cell
// that the point falls in and gives nothing back; a point outside the grid is
// dropped. A query returns one transaction on res: occupied and out_of_bounds,
// a point outside the grid reading as occupied.
// The user must write registers through cfg_we/cfg_idx/cfg_data only while no
// point is in flight; the block does not enforce this. Cell index per axis is
// round((pos - origin) * inv_resolution). Throughput: one point per cycle when
// res is not stalled. A query passes offset on acceptance, multiply, round and
// address with memory read, and the result register before it is valid on res.
// The grid is stored as MAX_CELLS_X * MAX_CELLS_Y rows of MAX_CELLS_Z bits in
// one memory with a registered read; a mark rewrites the whole row, and the row
// written on the previous advance is forwarded to the next read of that row.
// After reset, pts.ready stays low while all MAX_CELLS_X * MAX_CELLS_Y rows
// (4096 by default) of the memory are cleared one row a cycle.
// When res is stalled the whole pipeline holds and pts.ready drops; the
// result register keeps its transaction until it is taken.
module voxel_occupancy_grid #(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int MAX_CELLS_Z = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  vog_pkg::cfg_idx_t         cfg_idx,
  input  vog_pkg::cfg_data_t        cfg_data,
  vog_point_if.sink                 pts,
  vog_result_if.source              res
);
  import vog_pkg::*;

  localparam int ROWS  = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ZW    = (MAX_CELLS_Z > 1) ? $clog2(MAX_CELLS_Z) : 1;

  logic signed [POS_W-1:0]   origin_x, origin_y, origin_z;
  logic        [CELLS_W-1:0] cells_x, cells_y, cells_z;
  logic        [INV_W-1:0]   inv_resolution;

  grid_state_t state, state_next;
  logic [ROW_W-1:0] clr_row;
  logic             clr_last;

  logic en;
  logic load;

  lookup_ctl_t      ctl2;
  logic [ROW_W-1:0] row2;
  logic [ZW-1:0]    zb2;

  logic             v3, op3, inb3;
  logic [ROW_W-1:0] row3;
  logic [ZW-1:0]    zb3;

  logic [MAX_CELLS_Z-1:0] grid [ROWS];
  logic [MAX_CELLS_Z-1:0] mem_q;
  logic [MAX_CELLS_Z-1:0] row_cur;
  logic [MAX_CELLS_Z-1:0] row_set;

  logic                   fw_valid;
  logic [ROW_W-1:0]       fw_row;
  logic [MAX_CELLS_Z-1:0] fw_data;

  logic                   mark_wr;
  logic                   wr_en;
  logic [ROW_W-1:0]       wr_row;
  logic [MAX_CELLS_Z-1:0] wr_data;
  logic                   cell_bit;

  logic    res_valid;
  result_t res_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      origin_z       <= '0;
      cells_x        <= '0;
      cells_y        <= '0;
      cells_z        <= '0;
      inv_resolution <= INV_W'(32'h0001_0000);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ORIGIN_X: origin_x       <= cfg_data[POS_W-1:0];
        CFG_ORIGIN_Y: origin_y       <= cfg_data[POS_W-1:0];
        CFG_ORIGIN_Z: origin_z       <= cfg_data[POS_W-1:0];
        CFG_CELLS_X:  cells_x        <= cfg_data[CELLS_W-1:0];
        CFG_CELLS_Y:  cells_y        <= cfg_data[CELLS_W-1:0];
        CFG_CELLS_Z:  cells_z        <= cfg_data[CELLS_W-1:0];
        CFG_INV_RES:  inv_resolution <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  assign clr_last = (clr_row == ROW_W'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  // Whole pipeline advances together unless the result register is stuck.
  assign en        = !res_valid || res.ready;
  assign pts.ready = en && (state == ST_RUN);
  assign load      = pts.valid && pts.ready;

  vog_index #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y),
    .MAX_CELLS_Z (MAX_CELLS_Z)
  ) u_index (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .load           (load),
    .point          (pts.data),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .origin_z       (origin_z),
    .cells_x        (cells_x),
    .cells_y        (cells_y),
    .cells_z        (cells_z),
    .inv_resolution (inv_resolution),
    .ctl            (ctl2),
    .row            (row2),
    .zbit           (zb2)
  );

  // Memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3  <= ctl2.opcode;
      inb3 <= ctl2.inb;
      row3 <= row2;
      zb3  <= zb2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mem_q <= grid[row2];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid[wr_row] <= wr_data;
    end
  end

  // The row written on the previous advance is not yet visible in mem_q.
  assign row_cur  = (fw_valid && (fw_row == row3)) ? fw_data : mem_q;
  assign cell_bit = row_cur[zb3];
  assign row_set  = row_cur | (MAX_CELLS_Z'(1) << zb3);
  assign mark_wr  = en && v3 && (op3 == OP_MARK) && inb3;

  assign wr_en   = (state == ST_CLEAR) || mark_wr;
  assign wr_row  = (state == ST_CLEAR) ? clr_row : row3;
  assign wr_data = (state == ST_CLEAR) ? '0 : row_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (en) begin
      fw_valid <= mark_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fw_row  <= row3;
      fw_data <= row_set;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v3 && (op3 == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data.occupied      <= !inb3 || cell_bit;
      res_data.out_of_bounds <= !inb3;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

### dv/voxel_grid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voxel occupancy grid: tracks registers and cells, checks query results.
module voxel_grid_checker
  import vog_pkg::*;
#(
  parameter int MAX_CELLS_X = 64,
  parameter int MAX_CELLS_Y = 64,
  parameter int MAX_CELLS_Z = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_idx,
  input  cfg_data_t cfg_data,
  vog_point_if      pts,
  vog_result_if     res,
  output int        fail_count,
  output int        pending
);

  localparam int GRID_CELLS = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;

  bit                      cell_bits [GRID_CELLS];
  logic signed [POS_W-1:0] org_x, org_y, org_z;
  logic [CELLS_W-1:0]      span_x, span_y, span_z;
  logic [INV_W-1:0]        inv_res;
  result_t                 query_answers [$];

  // Exact index on one axis; returns 0 when the point falls outside the axis.
  function automatic bit axis_cell(input logic signed [POS_W-1:0] pos, org,
                                   input logic [CELLS_W-1:0] cells, input int max_cells,
                                   input logic [INV_W-1:0] inv, output int idx);
    longint diff, prod, q;
    int     usable;
    idx    = 0;
    diff   = longint'(pos) - longint'(org);
    prod   = diff * longint'(inv);
    usable = (cells < max_cells) ? cells : max_cells;
    if (prod >= 0) begin
      q = (prod + 64'sd8388608) >>> 24;
    end else begin
      // only a negative product that rounds to zero stays in the grid
      q = (-prod + 64'sd8388608) >>> 24;
      if (q != 0) return 1'b0;
    end
    if (q >= usable) return 1'b0;
    idx = int'(q);
    return 1'b1;
  endfunction

  task automatic take_point(input point_t p);
    int      ix, iy, iz, addr;
    bit      inb;
    result_t r;
    inb  = axis_cell(p.pos_x, org_x, span_x, MAX_CELLS_X, inv_res, ix);
    inb  = axis_cell(p.pos_y, org_y, span_y, MAX_CELLS_Y, inv_res, iy) && inb;
    inb  = axis_cell(p.pos_z, org_z, span_z, MAX_CELLS_Z, inv_res, iz) && inb;
    addr = (ix * MAX_CELLS_Y + iy) * MAX_CELLS_Z + iz;
    if (p.opcode == OP_MARK) begin
      if (inb) cell_bits[addr] = 1'b1;
    end else begin
      r.out_of_bounds = !inb;
      r.occupied      = 1'b1;
      if (inb) r.occupied = cell_bits[addr];
      query_answers.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (cell_bits[i]) cell_bits[i] = 1'b0;
      org_x   = '0;
      org_y   = '0;
      org_z   = '0;
      span_x  = '0;
      span_y  = '0;
      span_z  = '0;
      inv_res = INV_W'(65536);
      query_answers.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ORIGIN_X: org_x   = cfg_data[POS_W-1:0];
          CFG_ORIGIN_Y: org_y   = cfg_data[POS_W-1:0];
          CFG_ORIGIN_Z: org_z   = cfg_data[POS_W-1:0];
          CFG_CELLS_X:  span_x  = cfg_data[CELLS_W-1:0];
          CFG_CELLS_Y:  span_y  = cfg_data[CELLS_W-1:0];
          CFG_CELLS_Z:  span_z  = cfg_data[CELLS_W-1:0];
          CFG_INV_RES:  inv_res = cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
      if (pts.valid && pts.ready) take_point(pts.data);
      if (res.valid && res.ready) begin
        if (query_answers.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transaction with no query outstanding: occupied=%0b out_of_bounds=%0b",
                     $time, res.data.occupied, res.data.out_of_bounds);
          fail_count <= fail_count + 1;
        end else begin
          want = query_answers.pop_front();
          if (res.data.occupied !== want.occupied ||
              res.data.out_of_bounds !== want.out_of_bounds) begin
            if (fail_count < 10)
              $display("%0t: query result mismatch: expected occupied=%0b out_of_bounds=%0b, got occupied=%0b out_of_bounds=%0b",
                       $time, want.occupied, want.out_of_bounds,
                       res.data.occupied, res.data.out_of_bounds);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= query_answers.size();
    end
  end

endmodule

### dv/tb_voxel_occupancy_grid.sv
`timescale 1ns / 1ps
// Testbench top for the voxel occupancy grid: clock, reset, stimulus and verdict.
module tb_voxel_occupancy_grid;
  import vog_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;
  int        fail_count;
  int        pending;
  int        idle_cycles;
  int        ready_phase;
  int        burst_left;
  longint    cur_org [3];
  longint    cur_inv;
  int        cur_cells [3];
  int        hot_lo [3];
  point_t    marked [$];

  vog_point_if  pts_ch ();
  vog_result_if res_ch ();

  voxel_occupancy_grid uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pts      (pts_ch),
    .res      (res_ch)
  );

  voxel_grid_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .pts        (pts_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side stall pattern, stepping through a sequence of modes.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1;
    case ((ready_phase >> 7) % 8)
      0, 3:    res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 99) < 50);
      2:       res_ch.ready <= (ready_phase % 3 == 0);
      4:       res_ch.ready <= ((ready_phase % 16) < 4);
      5:       res_ch.ready <= ($urandom_range(0, 99) < 85);
      6:       res_ch.ready <= ((ready_phase >> 5) % 2 == 0);
      default: res_ch.ready <= ($urandom_range(0, 99) < 25);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (pts_ch.valid && pts_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(input point_t p);
    int gap;
    pts_ch.valid <= 1'b1;
    pts_ch.data  <= p;
    do @(posedge clk); while (!pts_ch.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      pts_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_point(input logic op, input logic signed [POS_W-1:0] x, y, z);
    point_t p;
    p.opcode = op;
    p.pos_x  = x;
    p.pos_y  = y;
    p.pos_z  = z;
    send_point(p);
  endtask

  // Lower valid, wait until every query answer is in, then let marks settle.
  task automatic drain(input int settle);
    pts_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input longint ox, oy, oz, input int cx, cy, cz,
                               input longint inv);
    int usable;
    write_reg(CFG_ORIGIN_X, cfg_data_t'(ox));
    write_reg(CFG_ORIGIN_Y, cfg_data_t'(oy));
    write_reg(CFG_ORIGIN_Z, cfg_data_t'(oz));
    // upper data bits are don't-care for the cell counts
    write_reg(CFG_CELLS_X, {17'($urandom), 7'(cx)});
    write_reg(CFG_CELLS_Y, {17'($urandom), 7'(cy)});
    write_reg(CFG_CELLS_Z, {17'($urandom), 7'(cz)});
    write_reg(CFG_INV_RES, cfg_data_t'(inv));
    cfg_we <= 1'b0;
    cur_org   = '{ox, oy, oz};
    cur_cells = '{cx, cy, cz};
    cur_inv   = inv;
    for (int a = 0; a < 3; a++) begin
      usable    = (cur_cells[a] < 64) ? cur_cells[a] : 64;
      hot_lo[a] = (usable > 4) ? $urandom_range(0, usable - 4) : 0;
    end
  endtask

  // Mostly lands near cell centers and edges of a small hot region.
  function automatic logic [POS_W-1:0] pick_coord(input int axis);
    longint idx, base, half, p;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return POS_W'($urandom);
    if (cur_inv == 0) return POS_W'(cur_org[axis] + longint'($urandom_range(0, 2000)) - 1000);
    if (sel < 65) idx = hot_lo[axis] + $urandom_range(0, 3);
    else if (sel < 95) idx = $urandom_range(0, cur_cells[axis] + 1);
    else idx = -1;
    base = (idx * 64'sd16777216) / cur_inv;
    half = 64'sd8388608 / cur_inv;
    p    = cur_org[axis] + base + longint'($urandom_range(0, 32'(2 * half))) - half;
    return POS_W'(p);
  endfunction

  task automatic rand_item();
    point_t p;
    p.opcode = ($urandom_range(0, 99) < 45) ? OP_MARK : OP_QUERY;
    if (p.opcode == OP_QUERY && marked.size() > 0 && $urandom_range(0, 3) == 0) begin
      p        = marked[$urandom_range(0, marked.size() - 1)];
      p.opcode = OP_QUERY;
    end else begin
      p.pos_x = pick_coord(0);
      p.pos_y = pick_coord(1);
      p.pos_z = pick_coord(2);
    end
    if (p.opcode == OP_MARK) begin
      marked.push_back(p);
      if (marked.size() > 64) marked.delete(0);
    end
    send_point(p);
  endtask

  task automatic random_phase(input int n);
    repeat (n) rand_item();
    drain(8);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_ORIGIN_X;
    cfg_data     = '0;
    pts_ch.valid = 1'b0;
    pts_ch.data  = '0;
    res_ch.ready = 1'b0;
    ready_phase  = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    cur_org      = '{0, 0, 0};
    cur_cells    = '{0, 0, 0};
    cur_inv      = 65536;
    hot_lo       = '{0, 0, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: no cells, so everything is out of bounds and marks drop
    put_point(OP_QUERY, 0, 0, 0);
    put_point(OP_MARK, 0, 0, 0);
    drain(8);

    // one cell per meter, 256 LSBs per cell
    apply_setting(0, 0, 0, 64, 64, 64, 65536);
    put_point(OP_QUERY, 0, 0, 0);
    put_point(OP_MARK, 0, 0, 0);
    put_point(OP_QUERY, 0, 0, 0);
    put_point(OP_MARK, 16128, 16128, 16128);
    put_point(OP_QUERY, 16128, 16128, 16128);
    put_point(OP_QUERY, 16256, 0, 0);
    put_point(OP_QUERY, -128, 0, 0);
    put_point(OP_QUERY, -127, 256, 0);
    put_point(OP_MARK, -127, 256, 0);
    put_point(OP_QUERY, 0, 256, 0);
    put_point(OP_MARK, 128, 0, 0);
    put_point(OP_QUERY, 256, 0, 0);
    put_point(OP_QUERY, 383, 0, 0);
    put_point(OP_QUERY, 384, 0, 0);
    put_point(OP_QUERY, 8388607, -8388608, 0);
    put_point(OP_QUERY, -8388608, -8388608, -8388608);
    put_point(OP_MARK, 8388607, 8388607, 8388607);
    put_point(OP_QUERY, 8388607, 8388607, 8388607);
    random_phase(250);

    // extreme origins, finest resolution, a single cell and an oversized count
    apply_setting(-8388608, 8388607, -1000, 1, 127, 64, 16777215);
    random_phase(200);

    // zero resolution folds every point onto index 0
    apply_setting(longint'($urandom_range(0, 4000)) - 2000,
                  longint'($urandom_range(0, 4000)) - 2000,
                  longint'($urandom_range(0, 4000)) - 2000, 3, 5, 7, 0);
    random_phase(150);

    // empty z axis: all points outside
    apply_setting(0, 0, 0, 64, 64, 0, 65536);
    random_phase(100);

    // smaller grid over the first setting: earlier marks must still read back
    apply_setting(0, 0, 0, 16, 16, 16, 65536);
    random_phase(150);

    repeat (3) begin
      longint inv;
      case ($urandom_range(0, 2))
        0:       inv = 65536 * $urandom_range(1, 8);
        1:       inv = $urandom_range(4096, 16777215);
        default: inv = $urandom_range(4096, 65536);
      endcase
      apply_setting(longint'($urandom_range(0, 60000)) - 30000,
                    longint'($urandom_range(0, 60000)) - 30000,
                    longint'($urandom_range(0, 60000)) - 30000,
                    $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64), inv);
      random_phase(150);
    end

    apply_setting(-2000, -2000, -2000, 127, 127, 127, 4 * 65536);
    random_phase(200);

    drain(10);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
